@@ src/ipv4_stride8_trie_store_lookup_assert.svh @@
// Assertion macros shared by the trie lookup modules.
`ifndef IPV4_STRIDE8_TRIE_STORE_LOOKUP_ASSERT_SVH
`define IPV4_STRIDE8_TRIE_STORE_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IPTRIE_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPTRIE_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ src/iptrie_pkg.sv @@
// Shared types and constants of the IPv4 stride-8 trie store and lookup block.
package iptrie_pkg;

    localparam int NODE_COUNT  = 1024;
    localparam int FANOUT      = 256;
    localparam int VALUE_BITS  = 16;
    localparam int LEVELS      = 4;
    localparam int OCTET_BITS  = 8;
    localparam int ADDR_BITS   = 32;
    localparam int OUT_VALUE_BITS = 16;

    localparam int NODE_BITS   = $clog2(NODE_COUNT);
    localparam int FREE_BITS   = $clog2(NODE_COUNT + 1);
    localparam int LEVEL_BITS  = $clog2(LEVELS);
    localparam int DATA_BITS   = (VALUE_BITS > NODE_BITS) ? VALUE_BITS : NODE_BITS;
    localparam int MEM_DEPTH   = NODE_COUNT * FANOUT;
    localparam int MEM_ADDR_BITS = NODE_BITS + OCTET_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_CHILD,
        KIND_VALUE
    } kind_t;

    typedef enum logic {
        OP_LOOKUP,
        OP_STORE
    } op_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_LINK,
        S_CLEAR,
        S_WVAL,
        S_DONE
    } state_t;

    typedef struct packed {
        kind_t                 kind;
        logic [DATA_BITS-1:0]  data;
    } entry_t;

    typedef struct packed {
        logic                  cmd;
        logic [ADDR_BITS-1:0]  address;
        logic [15:0]           store_value;
    } in_item_t;

    typedef struct packed {
        logic                       found;
        logic [OUT_VALUE_BITS-1:0]  result_value;
        logic                       status;
    } out_item_t;

    // Classified work item; octets[0] is the root-level octet.
    typedef struct packed {
        op_t                                op;
        logic [LEVELS-1:0][OCTET_BITS-1:0]  octets;
        logic [VALUE_BITS-1:0]              value;
    } job_t;

endpackage

@@ src/iptrie_front.sv @@
// Front end: accepts requests, classifies them into jobs and queues them for the back end.
`include "ipv4_stride8_trie_store_lookup_assert.svh"

module iptrie_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  iptrie_pkg::in_item_t req,
    input  logic                 init_done,
    output logic                 job_valid,
    output iptrie_pkg::job_t     job,
    input  logic                 job_pop
);
    import iptrie_pkg::*;

    job_t                 q_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 push;
    job_t                 job_in;

    // Classify the request: decode the operation, split the address into octets, carry the store value
    always_comb
    begin
        job_in.op = req.cmd ? OP_STORE : OP_LOOKUP;
        for (int i = 0; i < LEVELS; i++)
        begin
            job_in.octets[i] = req.address[ADDR_BITS-1-OCTET_BITS*i -: OCTET_BITS];
        end
        job_in.value = VALUE_BITS'(req.store_value);
    end

    // Take a transfer only after the root clear and while the queue has room
    assign req_ready = init_done && (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign push      = req_valid && req_ready;
    assign job_valid = (count_reg != '0);
    assign job       = q_mem[rd_ptr_reg];

    // Advance the queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (job_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !job_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && job_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= job_in;
        end
    end

    `IPTRIE_ASSERT_IMPLY(a_front_pop_nonempty, clk, rst_n, job_pop, count_reg != '0, "pop from empty job queue")
    `IPTRIE_ASSERT_IMPLY(a_front_no_accept_in_init, clk, rst_n, !init_done, !push, "request taken during root clear")
    `IPTRIE_ASSERT_NEXT(a_front_count_step, clk, rst_n, push && !job_pop, count_reg == $past(count_reg) + 1'b1, "queue count did not advance on push")

endmodule

@@ src/iptrie_back.sv @@
// Back end: trie node memory, walk sequencer, node allocation and result register.
`include "ipv4_stride8_trie_store_lookup_assert.svh"

module iptrie_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  iptrie_pkg::job_t      job,
    output logic                  job_pop,
    output logic                  init_done,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output iptrie_pkg::out_item_t rsp
);
    import iptrie_pkg::*;

    localparam logic [LEVEL_BITS-1:0] LAST_LEVEL = LEVEL_BITS'(LEVELS - 1);
    localparam logic [OCTET_BITS-1:0] LAST_SLOT  = OCTET_BITS'(FANOUT - 1);

    state_t                 state_reg, state_next;
    logic [LEVEL_BITS-1:0]  level_reg, level_next;
    logic [NODE_BITS-1:0]   node_reg, node_next;
    logic [FREE_BITS-1:0]   free_reg, free_next;
    logic [OCTET_BITS-1:0]  cnt_reg, cnt_next;
    job_t                   job_reg, job_next;
    out_item_t              res_reg, res_next;
    out_item_t              out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    entry_t                 mem [MEM_DEPTH];
    entry_t                 rd_data_reg;
    logic                   mem_we, mem_re;
    logic [MEM_ADDR_BITS-1:0] mem_waddr, mem_raddr;
    entry_t                 mem_wdata;

    logic [OCTET_BITS-1:0]  cur_octet;
    logic [FREE_BITS-1:0]   avail;
    logic [LEVEL_BITS-1:0]  needed;
    logic                   pool_short;
    logic                   is_child;
    logic                   out_free;

    // Derive walk conditions from the current entry
    assign cur_octet  = job_reg.octets[level_reg];
    assign avail      = FREE_BITS'(NODE_COUNT) - free_reg;
    assign needed     = LAST_LEVEL - level_reg;
    assign pool_short = FREE_BITS'(needed) > avail;
    assign is_child   = (rd_data_reg.kind == KIND_CHILD);
    assign out_free   = !out_valid_reg || rsp_ready;

    assign init_done  = (state_reg != S_INIT);
    assign rsp_valid  = out_valid_reg;
    assign rsp        = out_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (job_reg.op == OP_LOOKUP)
                begin
                    if (is_child && level_reg != LAST_LEVEL)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (is_child)
                begin
                    state_next = (level_reg == LAST_LEVEL - 1'b1) ? S_WVAL : S_READ;
                end
                else
                begin
                    state_next = pool_short ? S_DONE : S_LINK;
                end
            end
            S_LINK:
            begin
                state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = (level_reg == LAST_LEVEL - 1'b1) ? S_WVAL : S_LINK;
                end
            end
            S_WVAL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        level_next     = level_reg;
        node_next      = node_reg;
        free_next      = free_reg;
        cnt_next       = cnt_reg;
        job_next       = job_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        job_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = {node_reg, cur_octet};
        mem_wdata      = '{kind: KIND_EMPTY, data: '0};
        mem_re         = 1'b0;
        mem_raddr      = {node_reg, cur_octet};
        case (state_reg)
            S_INIT:
            begin
                // Clear the root node, one entry a cycle
                mem_we    = 1'b1;
                mem_waddr = {NODE_BITS'(0), cnt_reg};
                cnt_next  = cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    job_next   = job;
                    level_next = '0;
                    node_next  = '0;
                    res_next   = '0;
                end
            end
            S_READ:
            begin
                mem_re = 1'b1;
            end
            S_CHECK:
            begin
                if (job_reg.op == OP_LOOKUP)
                begin
                    if (rd_data_reg.kind == KIND_VALUE)
                    begin
                        res_next.found        = 1'b1;
                        res_next.result_value = OUT_VALUE_BITS'(rd_data_reg.data);
                    end
                    else if (is_child && level_reg != LAST_LEVEL)
                    begin
                        node_next  = NODE_BITS'(rd_data_reg.data);
                        level_next = level_reg + 1'b1;
                    end
                end
                else if (is_child)
                begin
                    node_next  = NODE_BITS'(rd_data_reg.data);
                    level_next = level_reg + 1'b1;
                end
                else if (pool_short)
                begin
                    res_next.status = 1'b1;
                end
            end
            S_LINK:
            begin
                // Point the missing entry at a fresh node
                mem_we         = 1'b1;
                mem_wdata.kind = KIND_CHILD;
                mem_wdata.data = DATA_BITS'(free_reg);
                node_next      = NODE_BITS'(free_reg);
                free_next      = free_reg + 1'b1;
                cnt_next       = '0;
            end
            S_CLEAR:
            begin
                // Sweep the fresh node empty
                mem_we    = 1'b1;
                mem_waddr = {node_reg, cnt_reg};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_SLOT)
                begin
                    level_next = level_reg + 1'b1;
                end
            end
            S_WVAL:
            begin
                mem_we         = 1'b1;
                mem_wdata.kind = KIND_VALUE;
                mem_wdata.data = DATA_BITS'(job_reg.value);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            level_reg     <= '0;
            node_reg      <= '0;
            free_reg      <= FREE_BITS'(1);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            node_reg      <= node_next;
            free_reg      <= free_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // Node memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    `IPTRIE_ASSERT_IMPLY(a_back_free_bound, clk, rst_n, 1'b1, free_reg <= FREE_BITS'(NODE_COUNT) && free_reg != '0, "node pool counter out of range")
    `IPTRIE_ASSERT_IMPLY(a_back_write_allocated, clk, rst_n, state_reg == S_CLEAR || state_reg == S_WVAL, FREE_BITS'(node_reg) < free_reg, "write to a node never allocated")
    `IPTRIE_ASSERT_IMPLY(a_back_status_on_store, clk, rst_n, state_reg == S_DONE && res_reg.status, job_reg.op == OP_STORE && !res_reg.found, "pool-full status on a lookup")
    `IPTRIE_ASSERT_NEXT(a_back_link_allocates, clk, rst_n, state_reg == S_LINK, free_reg == $past(free_reg) + 1'b1, "link did not take a node from the pool")

endmodule

@@ src/ipv4_stride8_trie_store_lookup.sv @@
// Top level of the IPv4 stride-8 trie store and lookup block.
// Each request is a lookup or a store of a 16-bit value under a 32-bit IPv4 address, walked
// through a four-level trie of 256-way nodes held in one single-port-style node memory (one
// read or one write a cycle, registered read). After reset the block clears the root node,
// one entry a cycle, and takes no request until that clear is done. A lookup starts, reads
// and then checks each trie level it visits, up to four, and then hands over its result.
// A store whose path already exists walks it and then writes its value. A store that must
// allocate child nodes stops reading at the first empty entry and spends one link write
// plus a clear of all 256 entries on each of the one, two or three new nodes.
// A store that needs more nodes than remain changes nothing and reports status 1. Up to two
// requests queue in front of the walker, and a finished result waits in an output register.
module ipv4_stride8_trie_store_lookup (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  iptrie_pkg::in_item_t  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output iptrie_pkg::out_item_t rsp
);
    import iptrie_pkg::*;

    logic job_valid;
    logic job_pop;
    logic init_done;
    job_t job;

    iptrie_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .init_done (init_done),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    iptrie_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .init_done (init_done),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
